// ===== design/ffba_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ffba_pkg;

  localparam int unsigned PoolUnitsDefault = 1024;

  localparam int unsigned CmdW    = 2;
  localparam int unsigned StartW  = 10;
  localparam int unsigned LenW    = 11;
  localparam int unsigned StatusW = 2;
  localparam int unsigned UsedW   = 11;

  typedef enum logic [CmdW-1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_QUERY = 2'd2
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK      = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_BAD     = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_MARK,
    S_FREE,
    S_RESP
  } state_e;

  typedef struct packed {
    logic [CmdW-1:0]   cmd;
    logic [StartW-1:0] block_start;
    logic [LenW-1:0]   block_length;
  } in_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [StartW-1:0]  granted_start;
    logic [UsedW-1:0]   used_units;
  } out_t;

endpackage

`default_nettype wire

// ===== design/ffba_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ffba_ram #(
  parameter int unsigned Width = 1,
  parameter int unsigned Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== design/first_fit_bitmap_allocator.sv =====
// query and rejected commands go from the decode state straight to the result state
// allocate: scans the map upward from unit 0 for the first free run of the length,
//   marks it used, or reports no space at the pool end; free: clears the range
// one command in flight; the next transfer is taken once the result is registered
// reset: a pass over every unit clears the used map, input stalled until it ends
`timescale 1ns / 1ps
`default_nettype none

module first_fit_bitmap_allocator
  import ffba_pkg::*;
#(
  parameter int unsigned PoolUnits = PoolUnitsDefault
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  input  wire in_t  in_data_i,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output out_t      out_data_o
);

  localparam int unsigned IdxW = $clog2(PoolUnits);
  localparam int unsigned CntW = $clog2(PoolUnits + 1);
  localparam int unsigned CmpW = ((CntW > LenW) ? CntW : LenW) + 1;
  localparam logic [CntW-1:0] PoolCnt = CntW'(PoolUnits);
  localparam logic [CmpW-1:0] PoolCmp = CmpW'(PoolUnits);

  state_e state_q, state_d;

  logic [CmdW-1:0]   cmd_q, cmd_d;
  logic [StartW-1:0] start_q, start_d;
  logic [LenW-1:0]   len_q, len_d;
  logic [CntW-1:0]   ptr_q, ptr_d;
  logic [CntW-1:0]   lim_q, lim_d;
  logic [CntW-1:0]   run_q, run_d;
  logic [CntW-1:0]   used_q, used_d;
  logic              chk_vld_q, chk_vld_d;
  status_e           status_q, status_d;
  logic [IdxW-1:0]   grant_q, grant_d;
  out_t              out_q, out_d;
  logic              out_valid_q, out_valid_d;

  logic            ram_we;
  logic [IdxW-1:0] ram_waddr;
  logic [0:0]      ram_wdata;
  logic            ram_re;
  logic [IdxW-1:0] ram_raddr;
  logic [0:0]      ram_rdata;

  logic            in_take;
  logic [CmpW-1:0] len_cmp;
  logic [CmpW-1:0] start_cmp;
  logic [CmpW-1:0] end_cmp;
  logic            len_bad;
  logic            rng_bad;
  logic [CntW-1:0] chk_idx;
  logic [CntW-1:0] run_inc;
  logic [CntW-1:0] first_idx;
  logic            hit;
  logic            scan_end;
  logic            free_end;
  logic            mark_last;
  logic            clear_last;
  logic            resp_go;

  ffba_ram #(
    .Width(1),
    .Depth(PoolUnits)
  ) u_map (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_take     = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign len_cmp   = CmpW'(len_q);
  assign start_cmp = CmpW'(start_q);
  assign end_cmp   = start_cmp + len_cmp;
  assign len_bad   = (len_q == '0) || (len_cmp > PoolCmp);
  assign rng_bad   = (len_q == '0) || (start_cmp >= PoolCmp) || (end_cmp > PoolCmp);

  // the read issued last cycle belongs to the unit just below the pointer
  assign chk_idx    = ptr_q - CntW'(1);
  assign run_inc    = run_q + CntW'(1);
  assign first_idx  = ptr_q - CntW'(len_q);
  assign hit        = chk_vld_q && !ram_rdata[0] && (CmpW'(run_inc) == len_cmp);
  assign scan_end   = chk_vld_q && (ptr_q == PoolCnt);
  assign free_end   = chk_vld_q && (ptr_q == lim_q);
  assign mark_last  = (run_q == CntW'(1));
  assign clear_last = (ptr_q == PoolCnt - CntW'(1));
  assign resp_go    = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (clear_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_take) state_d = S_DECODE;
      end
      S_DECODE: begin
        case (cmd_q)
          CMD_ALLOC: state_d = len_bad ? S_RESP : S_SCAN;
          CMD_FREE:  state_d = rng_bad ? S_RESP : S_FREE;
          default:   state_d = S_RESP;
        endcase
      end
      S_SCAN: begin
        if (hit) begin
          state_d = S_MARK;
        end else if (scan_end) begin
          state_d = S_RESP;
        end
      end
      S_MARK: begin
        if (mark_last) state_d = S_RESP;
      end
      S_FREE: begin
        if (free_end) state_d = S_RESP;
      end
      S_RESP: begin
        if (resp_go) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_d       = cmd_q;
    start_d     = start_q;
    len_d       = len_q;
    ptr_d       = ptr_q;
    lim_d       = lim_q;
    run_d       = run_q;
    used_d      = used_q;
    chk_vld_d   = chk_vld_q;
    status_d    = status_q;
    grant_d     = grant_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    ram_we      = 1'b0;
    ram_waddr   = ptr_q[IdxW-1:0];
    ram_wdata   = 1'b0;
    ram_re      = 1'b0;
    ram_raddr   = ptr_q[IdxW-1:0];
    case (state_q)
      S_CLEAR: begin
        ram_we = 1'b1;
        ptr_d  = clear_last ? '0 : ptr_q + CntW'(1);
      end
      S_IDLE: begin
        if (in_take) begin
          cmd_d   = in_data_i.cmd;
          start_d = in_data_i.block_start;
          len_d   = in_data_i.block_length;
        end
      end
      S_DECODE: begin
        status_d  = ST_OK;
        grant_d   = '0;
        ptr_d     = '0;
        run_d     = '0;
        chk_vld_d = 1'b0;
        case (cmd_q)
          CMD_ALLOC: begin
            if (len_bad) status_d = ST_BAD;
          end
          CMD_FREE: begin
            if (rng_bad) status_d = ST_BAD;
            ptr_d = CntW'(start_q);
            lim_d = CntW'(end_cmp);
          end
          CMD_QUERY: status_d = ST_OK;
          default:   status_d = ST_BAD;
        endcase
      end
      S_SCAN: begin
        chk_vld_d = 1'b1;
        if (ptr_q != PoolCnt) begin
          ram_re = 1'b1;
          ptr_d  = ptr_q + CntW'(1);
        end
        if (chk_vld_q) begin
          run_d = ram_rdata[0] ? '0 : run_inc;
        end
        if (hit) begin
          // rewind to the run start and count the marks down from the length
          ptr_d   = first_idx;
          run_d   = CntW'(len_q);
          grant_d = first_idx[IdxW-1:0];
        end else if (scan_end) begin
          status_d = ST_NOSPACE;
        end
      end
      S_MARK: begin
        ram_we    = 1'b1;
        ram_wdata = 1'b1;
        ptr_d     = ptr_q + CntW'(1);
        run_d     = run_q - CntW'(1);
        if (mark_last) used_d = used_q + CntW'(len_q);
      end
      S_FREE: begin
        chk_vld_d = 1'b1;
        if (ptr_q != lim_q) begin
          ram_re = 1'b1;
          ptr_d  = ptr_q + CntW'(1);
        end
        if (chk_vld_q) begin
          ram_we    = 1'b1;
          ram_waddr = chk_idx[IdxW-1:0];
          if (ram_rdata[0]) used_d = used_q - CntW'(1);
        end
      end
      S_RESP: begin
        if (resp_go) begin
          out_d.status        = status_q;
          out_d.granted_start = StartW'(grant_q);
          out_d.used_units    = UsedW'(used_q);
          out_valid_d         = 1'b1;
        end
      end
      default: begin
        ptr_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      ptr_q       <= '0;
      run_q       <= '0;
      used_q      <= '0;
      chk_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      run_q       <= run_d;
      used_q      <= used_d;
      chk_vld_q   <= chk_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    start_q  <= start_d;
    len_q    <= len_d;
    lim_q    <= lim_d;
    status_q <= status_d;
    grant_q  <= grant_d;
    out_q    <= out_d;
  end

`ifndef NO_ASSERTIONS
  a_used_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= PoolCnt)
    else $error("used count above pool size");

  a_fail_no_grant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != ST_OK) |-> (out_data_o.granted_start == '0))
    else $error("failed command reports a start index");

  a_scan_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> !ram_we)
    else $error("map written during scan");

  a_scan_count_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |=> (used_q == $past(used_q)))
    else $error("used count moved during scan");
`endif

endmodule

`default_nettype wire
